// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge out of reset
`define PST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define PST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and defaults of the pointer selection tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  // defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF   = 12;
  localparam int unsigned FRAC_BITS_DEF    = 8;
  localparam int unsigned MOVE_DIVISOR_DEF = 20;

  // fixed field widths
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // screen limits after reset
  localparam int unsigned COLS_RESET = 80;
  localparam int unsigned ROWS_RESET = 25;

  // configuration register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // pointer event codes
  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_MOVE     = 3'd1,
    OP_LPRESS   = 3'd2,
    OP_LRELEASE = 3'd3,
    OP_MPRESS   = 3'd4,
    OP_RPRESS   = 3'd5,
    OP_RRELEASE = 3'd6,
    OP_WHEEL    = 3'd7
  } op_e;

  // command codes
  typedef enum logic [2:0] {
    CMD_DRAW       = 3'd0,
    CMD_SEL_REGION = 3'd1,
    CMD_SEL_WORDS  = 3'd2,
    CMD_SEL_LINES  = 3'd3,
    CMD_REPORT     = 3'd4,
    CMD_PASTE      = 3'd5,
    CMD_SCROLL     = 3'd6
  } cmd_e;

  // button state codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  // selection granularity codes
  localparam logic [1:0] GRAN_REGION = 2'd0;
  localparam logic [1:0] GRAN_WORDS  = 2'd1;
  localparam logic [1:0] GRAN_LINES  = 2'd2;

  // scroll steps
  localparam logic signed [2:0] SCROLL_NONE = 3'sd0;
  localparam logic signed [2:0] SCROLL_UP   = 3'sd2;
  localparam logic signed [2:0] SCROLL_DOWN = -3'sd2;

endpackage

`default_nettype wire

// ===== rtl/pst_evt_if.sv =====
// ----------------------------------------------------------------------------
// pst_evt_if
// Pointer event channel: valid/ready handshake and event payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_evt_if;
  import pst_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [2:0]                   op;
  logic signed [VALUE_BITS-1:0] horiz_value;
  logic signed [VALUE_BITS-1:0] vert_value;

  modport source (output valid, output op, output horiz_value, output vert_value,
                  input ready);
  modport sink   (input valid, input op, input horiz_value, input vert_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/pst_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pst_cmd_if
// Command channel: valid/ready handshake and command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_cmd_if #(
  parameter int unsigned COORD_BITS = pst_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            command;
  logic [COORD_BITS-1:0] cursor_col;
  logic [COORD_BITS-1:0] cursor_row;
  logic [COORD_BITS-1:0] corner_col;
  logic [COORD_BITS-1:0] corner_row;
  logic [1:0]            button_state;
  logic signed [2:0]     scroll_amount;
  logic                  last;

  modport source (output valid, output command, output cursor_col, output cursor_row,
                  output corner_col, output corner_row, output button_state,
                  output scroll_amount, output last, input ready);
  modport sink   (input valid, input command, input cursor_col, input cursor_row,
                  input corner_col, input corner_row, input button_state,
                  input scroll_amount, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pst_cfg.sv =====
// ----------------------------------------------------------------------------
// pst_cfg
// APB register file holding the screen limits; a zero limit is used as one.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_cfg #(
  parameter int unsigned COORD_BITS = pst_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [COORD_BITS-1:0] cols_lim_o,
  output logic [COORD_BITS-1:0] rows_lim_o
);
  import pst_pkg::*;

  logic [COORD_BITS-1:0] cols_q;
  logic [COORD_BITS-1:0] rows_q;
  logic                  wr_en;
  logic                  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COORD_BITS'(COLS_RESET);
      rows_q <= COORD_BITS'(ROWS_RESET);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COLS: cols_q <= pwdata[COORD_BITS-1:0];
        REG_ROWS: rows_q <= pwdata[COORD_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_COLS: prdata = {{(32-COORD_BITS){1'b0}}, cols_q};
      REG_ROWS: prdata = {{(32-COORD_BITS){1'b0}}, rows_q};
      default:  prdata = '0;
    endcase
  end

  // clamp limits used by the datapath
  assign cols_lim_o = (cols_q == '0) ? COORD_BITS'(1) : cols_q;
  assign rows_lim_o = (rows_q == '0) ? COORD_BITS'(1) : rows_q;

endmodule

`default_nettype wire

// ===== rtl/pst_front.sv =====
// ----------------------------------------------------------------------------
// pst_front
// Event front end: accepts events, scales move deltas by 2^FRAC_BITS over
// MOVE_DIVISOR (reciprocal multiply plus one correction step) and drops
// wheel events of zero amount.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pst_front #(
  parameter int unsigned FRAC_BITS    = pst_pkg::FRAC_BITS_DEF,
  parameter int unsigned MOVE_DIVISOR = pst_pkg::MOVE_DIVISOR_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  pst_evt_if.sink                                       evt_i,
  output logic                                          q_valid_o,
  input  logic                                          q_ready_i,
  output pst_pkg::op_e                                  q_op_o,
  output logic signed [pst_pkg::VALUE_BITS-1:0]         q_horiz_o,
  output logic signed [pst_pkg::VALUE_BITS-1:0]         q_vert_o,
  output logic signed [pst_pkg::VALUE_BITS+FRAC_BITS:0] q_dcol_o,
  output logic signed [pst_pkg::VALUE_BITS+FRAC_BITS:0] q_drow_o
);
  import pst_pkg::*;

  localparam int unsigned MagBits   = VALUE_BITS + FRAC_BITS;
  localparam int unsigned RecipBits = MagBits + 1;
  localparam int unsigned ProdBits  = VALUE_BITS + RecipBits;
  localparam int unsigned RemBits   = MagBits + DIV_BITS + 1;
  localparam logic [RecipBits-1:0] RECIP = RecipBits'((64'd1 << MagBits) / MOVE_DIVISOR);
  localparam logic [DIV_BITS-1:0] DIVISOR = DIV_BITS'(MOVE_DIVISOR);

  // magnitude of a signed value
  function automatic logic [VALUE_BITS-1:0] mag_of(input logic signed [VALUE_BITS-1:0] x);
    return x[VALUE_BITS-1] ? -x : x;
  endfunction

  // estimate is the quotient or one below it; one compare fixes it
  function automatic logic [MagBits-1:0] quot_fix(input logic [MagBits-1:0] mag,
                                                  input logic [MagBits-1:0] est);
    logic [RemBits-1:0] rem;
    rem = RemBits'(mag) - RemBits'(est) * RemBits'(DIVISOR);
    return (rem >= RemBits'(DIVISOR)) ? est + MagBits'(1) : est;
  endfunction

  // stage 1: accepted event
  logic                         s1_valid_q;
  op_e                          s1_op_q;
  logic signed [VALUE_BITS-1:0] s1_h_q;
  logic signed [VALUE_BITS-1:0] s1_v_q;

  // stage 2: magnitudes and quotient estimates
  logic                         s2_valid_q;
  op_e                          s2_op_q;
  logic signed [VALUE_BITS-1:0] s2_h_q;
  logic signed [VALUE_BITS-1:0] s2_v_q;
  logic [MagBits-1:0]           s2_hmag_q;
  logic [MagBits-1:0]           s2_vmag_q;
  logic [MagBits-1:0]           s2_hest_q;
  logic [MagBits-1:0]           s2_vest_q;

  logic                         s1_adv;
  logic                         s2_adv;
  logic                         s2_free;
  logic                         s2_drop;
  logic [VALUE_BITS-1:0]        h_abs;
  logic [VALUE_BITS-1:0]        v_abs;
  logic [ProdBits-1:0]          h_prod;
  logic [ProdBits-1:0]          v_prod;
  logic [MagBits-1:0]           h_quot;
  logic [MagBits-1:0]           v_quot;

  // pipeline flow control
  assign s2_drop   = (s2_op_q == OP_WHEEL) && (s2_v_q == '0);
  assign s2_adv    = s2_valid_q && (s2_drop || q_ready_i);
  assign s2_free   = !s2_valid_q || s2_adv;
  assign s1_adv    = s1_valid_q && s2_free;
  assign evt_i.ready = !s1_valid_q || s2_free;
  assign q_valid_o = s2_valid_q && !s2_drop;

  // reciprocal multiply, stage 1 to 2
  assign h_abs  = mag_of(s1_h_q);
  assign v_abs  = mag_of(s1_v_q);
  assign h_prod = ProdBits'(h_abs) * ProdBits'(RECIP);
  assign v_prod = ProdBits'(v_abs) * ProdBits'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        s1_valid_q <= evt_i.valid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_op_q <= op_e'(evt_i.op);
      s1_h_q  <= evt_i.horiz_value;
      s1_v_q  <= evt_i.vert_value;
    end
    if (s1_adv) begin
      s2_op_q   <= s1_op_q;
      s2_h_q    <= s1_h_q;
      s2_v_q    <= s1_v_q;
      s2_hmag_q <= {h_abs, {FRAC_BITS{1'b0}}};
      s2_vmag_q <= {v_abs, {FRAC_BITS{1'b0}}};
      s2_hest_q <= h_prod[VALUE_BITS +: MagBits];
      s2_vest_q <= v_prod[VALUE_BITS +: MagBits];
    end
  end

  // quotient correction and sign, truncated toward zero
  assign h_quot = quot_fix(s2_hmag_q, s2_hest_q);
  assign v_quot = quot_fix(s2_vmag_q, s2_vest_q);

  assign q_op_o    = s2_op_q;
  assign q_horiz_o = s2_h_q;
  assign q_vert_o  = s2_v_q;
  assign q_dcol_o  = s2_h_q[VALUE_BITS-1] ? -$signed({1'b0, h_quot}) : $signed({1'b0, h_quot});
  assign q_drow_o  = s2_v_q[VALUE_BITS-1] ? -$signed({1'b0, v_quot}) : $signed({1'b0, v_quot});

  // a stalled stage 2 keeps its estimate
  `PST_ASSERT(a_s2_hold, (s2_valid_q && !s2_adv) |=> (s2_valid_q && $stable(s2_hest_q)), "front stage 2 lost a stalled event")

endmodule

`default_nettype wire

// ===== rtl/pst_queue.sv =====
// ----------------------------------------------------------------------------
// pst_queue
// Short register FIFO decoupling the event front end from the command unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pst_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import pst_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q;
  logic [PtrBits-1:0] rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (cnt_q != CntBits'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PST_ASSERT(a_cnt_bound, cnt_q <= CntBits'(QUEUE_DEPTH), "queue fill count overran depth")

endmodule

`default_nettype wire

// ===== rtl/pst_back.sv =====
// ----------------------------------------------------------------------------
// pst_back
// Command unit: holds cursor, anchor, click cell, granularity and button
// state, and issues one command beat per cycle through an output register while
// the sink is ready. A second command of the same event waits in a pending register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pst_back #(
  parameter int unsigned COORD_BITS = pst_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pst_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  output logic                                          q_ready_o,
  input  logic [2:0]                                    q_op_i,
  input  logic signed [pst_pkg::VALUE_BITS-1:0]         q_horiz_i,
  input  logic signed [pst_pkg::VALUE_BITS-1:0]         q_vert_i,
  input  logic signed [pst_pkg::VALUE_BITS+FRAC_BITS:0] q_dcol_i,
  input  logic signed [pst_pkg::VALUE_BITS+FRAC_BITS:0] q_drow_i,
  input  logic [COORD_BITS-1:0]                         cols_lim_i,
  input  logic [COORD_BITS-1:0]                         rows_lim_i,
  pst_cmd_if.source                                     cmd_o
);
  import pst_pkg::*;

  localparam int unsigned PosBits   = COORD_BITS + FRAC_BITS;
  localparam int unsigned DeltaBits = VALUE_BITS + FRAC_BITS + 1;
  localparam int unsigned SumBits   = ((PosBits > DeltaBits) ? PosBits : DeltaBits) + 2;
  localparam int unsigned CellBits  = VALUE_BITS + 2;

  // absolute placement: value+1 clamped to 1..lim, as a whole cell
  function automatic logic [PosBits-1:0] set_pos(input logic signed [VALUE_BITS-1:0] val,
                                                 input logic [COORD_BITS-1:0] lim);
    logic signed [CellBits-1:0] cval;
    logic signed [CellBits-1:0] lims;
    logic [COORD_BITS-1:0]      res;
    cval = $signed({{2{val[VALUE_BITS-1]}}, val}) + $signed(CellBits'(1));
    lims = $signed({{(CellBits-COORD_BITS){1'b0}}, lim});
    if (cval < $signed(CellBits'(1))) begin
      res = COORD_BITS'(1);
    end else if (cval > lims) begin
      res = lim;
    end else begin
      res = cval[COORD_BITS-1:0];
    end
    return {res, {FRAC_BITS{1'b0}}};
  endfunction

  // relative move: pos+delta clamped to 1.0..lim
  function automatic logic [PosBits-1:0] move_pos(input logic [PosBits-1:0] pos,
                                                  input logic signed [DeltaBits-1:0] d,
                                                  input logic [COORD_BITS-1:0] lim);
    logic signed [SumBits-1:0] sum;
    logic signed [SumBits-1:0] one;
    logic signed [SumBits-1:0] top;
    sum = $signed({{(SumBits-PosBits){1'b0}}, pos})
        + $signed({{(SumBits-DeltaBits){d[DeltaBits-1]}}, d});
    one = $signed({{(SumBits-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}});
    top = $signed({{(SumBits-PosBits){1'b0}}, lim, {FRAC_BITS{1'b0}}});
    if (sum < one) begin
      return one[PosBits-1:0];
    end else if (sum > top) begin
      return top[PosBits-1:0];
    end
    return sum[PosBits-1:0];
  endfunction

  // select command for a granularity
  function automatic cmd_e sel_cmd(input logic [1:0] gran);
    case (gran)
      GRAN_WORDS: return CMD_SEL_WORDS;
      GRAN_LINES: return CMD_SEL_LINES;
      default:    return CMD_SEL_REGION;
    endcase
  endfunction

  // architectural state
  logic [PosBits-1:0]    pos_col_q, pos_col_d;
  logic [PosBits-1:0]    pos_row_q, pos_row_d;
  logic [COORD_BITS-1:0] anchor_col_q, anchor_col_d;
  logic [COORD_BITS-1:0] anchor_row_q, anchor_row_d;
  logic                  anchor_valid_q, anchor_valid_d;
  logic [COORD_BITS-1:0] click_col_q, click_col_d;
  logic [COORD_BITS-1:0] click_row_q, click_row_d;
  logic                  click_valid_q, click_valid_d;
  logic [1:0]            gran_q, gran_d;
  logic [1:0]            held_q, held_d;

  // output register and pending second beat
  logic                  out_valid_q;
  cmd_e                  out_cmd_q;
  logic [COORD_BITS-1:0] out_ccol_q;
  logic [COORD_BITS-1:0] out_crow_q;
  logic [COORD_BITS-1:0] out_kcol_q;
  logic [COORD_BITS-1:0] out_krow_q;
  logic [1:0]            out_btn_q;
  logic signed [2:0]     out_scr_q;
  logic                  out_last_q;
  logic                  pend_valid_q;
  cmd_e                  pend_cmd_q;
  logic [COORD_BITS-1:0] pend_kcol_q;
  logic [COORD_BITS-1:0] pend_krow_q;

  // decoded beats of the current event
  op_e                   op;
  logic [COORD_BITS-1:0] cur_col;
  logic [COORD_BITS-1:0] cur_row;
  cmd_e                  r1_cmd;
  logic [COORD_BITS-1:0] r1_kcol;
  logic [COORD_BITS-1:0] r1_krow;
  logic [1:0]            r1_btn;
  logic signed [2:0]     r1_scr;
  logic                  has2;
  cmd_e                  r2_cmd;
  logic [COORD_BITS-1:0] r2_kcol;
  logic [COORD_BITS-1:0] r2_krow;

  logic                  out_free;
  logic                  take;
  logic                  pend_move;

  assign op        = op_e'(q_op_i);
  assign cur_col   = pos_col_q[FRAC_BITS +: COORD_BITS];
  assign cur_row   = pos_row_q[FRAC_BITS +: COORD_BITS];
  assign out_free  = !out_valid_q || cmd_o.ready;
  assign q_ready_o = out_free && !pend_valid_q;
  assign take      = q_valid_i && q_ready_o;
  assign pend_move = pend_valid_q && out_free;

  // event decode and next state
  always_comb begin
    pos_col_d      = pos_col_q;
    pos_row_d      = pos_row_q;
    anchor_col_d   = anchor_col_q;
    anchor_row_d   = anchor_row_q;
    anchor_valid_d = anchor_valid_q;
    click_col_d    = click_col_q;
    click_row_d    = click_row_q;
    click_valid_d  = click_valid_q;
    gran_d         = gran_q;
    held_d         = held_q;
    r1_cmd         = CMD_DRAW;
    r1_kcol        = '0;
    r1_krow        = '0;
    r1_btn         = BTN_NONE;
    r1_scr         = SCROLL_NONE;
    has2           = 1'b0;
    r2_cmd         = CMD_SEL_REGION;
    r2_kcol        = '0;
    r2_krow        = '0;
    unique case (op)
      OP_SET: begin
        pos_col_d = set_pos(q_horiz_i, cols_lim_i);
        pos_row_d = set_pos(q_vert_i, rows_lim_i);
        if (anchor_valid_q) begin
          r1_cmd  = CMD_SEL_REGION;
          r1_kcol = anchor_col_q;
          r1_krow = anchor_row_q;
        end
      end
      OP_MOVE: begin
        pos_col_d = move_pos(pos_col_q, q_dcol_i, cols_lim_i);
        pos_row_d = move_pos(pos_row_q, q_drow_i, rows_lim_i);
        if (anchor_valid_q) begin
          r1_cmd  = sel_cmd(gran_q);
          r1_kcol = anchor_col_q;
          r1_krow = anchor_row_q;
        end
      end
      OP_LPRESS: begin
        held_d = BTN_LEFT;
        r1_cmd = CMD_REPORT;
        r1_btn = BTN_LEFT;
        // repeated click on the same cell steps the granularity
        if (click_valid_q && (click_col_q == cur_col) && (click_row_q == cur_row)) begin
          case (gran_q)
            GRAN_REGION: gran_d = GRAN_WORDS;
            GRAN_WORDS:  gran_d = GRAN_LINES;
            default:     gran_d = GRAN_REGION;
          endcase
        end else begin
          gran_d = GRAN_REGION;
        end
        has2           = 1'b1;
        r2_cmd         = sel_cmd(gran_d);
        r2_kcol        = cur_col;
        r2_krow        = cur_row;
        anchor_col_d   = cur_col;
        anchor_row_d   = cur_row;
        click_col_d    = cur_col;
        click_row_d    = cur_row;
        anchor_valid_d = 1'b1;
        click_valid_d  = 1'b1;
      end
      OP_LRELEASE: begin
        held_d         = BTN_NONE;
        r1_cmd         = CMD_REPORT;
        r1_btn         = BTN_NONE;
        anchor_valid_d = 1'b0;
      end
      OP_MPRESS: begin
        r1_cmd = CMD_PASTE;
      end
      OP_RPRESS: begin
        held_d  = BTN_RIGHT;
        r1_cmd  = CMD_REPORT;
        r1_btn  = BTN_RIGHT;
        has2    = click_valid_q;
        r2_kcol = click_col_q;
        r2_krow = click_row_q;
      end
      OP_RRELEASE: begin
        held_d = BTN_NONE;
        r1_cmd = CMD_REPORT;
        r1_btn = BTN_NONE;
      end
      OP_WHEEL: begin
        r1_cmd = CMD_SCROLL;
        r1_scr = q_vert_i[VALUE_BITS-1] ? SCROLL_DOWN : SCROLL_UP;
      end
      default: ;
    endcase
  end

  // state and beat control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_col_q      <= PosBits'(1) << FRAC_BITS;
      pos_row_q      <= PosBits'(1) << FRAC_BITS;
      anchor_col_q   <= '0;
      anchor_row_q   <= '0;
      anchor_valid_q <= 1'b0;
      click_col_q    <= '0;
      click_row_q    <= '0;
      click_valid_q  <= 1'b0;
      gran_q         <= GRAN_REGION;
      held_q         <= BTN_NONE;
      out_valid_q    <= 1'b0;
      pend_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        pos_col_q      <= pos_col_d;
        pos_row_q      <= pos_row_d;
        anchor_col_q   <= anchor_col_d;
        anchor_row_q   <= anchor_row_d;
        anchor_valid_q <= anchor_valid_d;
        click_col_q    <= click_col_d;
        click_row_q    <= click_row_d;
        click_valid_q  <= click_valid_d;
        gran_q         <= gran_d;
        held_q         <= held_d;
        out_valid_q    <= 1'b1;
        pend_valid_q   <= has2;
      end else if (pend_move) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (cmd_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // beat payload; cursor fields carry over to the second beat
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_cmd_q   <= r1_cmd;
      out_ccol_q  <= pos_col_d[FRAC_BITS +: COORD_BITS];
      out_crow_q  <= pos_row_d[FRAC_BITS +: COORD_BITS];
      out_kcol_q  <= r1_kcol;
      out_krow_q  <= r1_krow;
      out_btn_q   <= r1_btn;
      out_scr_q   <= r1_scr;
      out_last_q  <= !has2;
      pend_cmd_q  <= r2_cmd;
      pend_kcol_q <= r2_kcol;
      pend_krow_q <= r2_krow;
    end else if (pend_move) begin
      out_cmd_q  <= pend_cmd_q;
      out_kcol_q <= pend_kcol_q;
      out_krow_q <= pend_krow_q;
      out_btn_q  <= BTN_NONE;
      out_scr_q  <= SCROLL_NONE;
      out_last_q <= 1'b1;
    end
  end

  assign cmd_o.valid         = out_valid_q;
  assign cmd_o.command       = out_cmd_q;
  assign cmd_o.cursor_col    = out_ccol_q;
  assign cmd_o.cursor_row    = out_crow_q;
  assign cmd_o.corner_col    = out_kcol_q;
  assign cmd_o.corner_row    = out_krow_q;
  assign cmd_o.button_state  = out_btn_q;
  assign cmd_o.scroll_amount = out_scr_q;
  assign cmd_o.last          = out_last_q;

  `PST_ASSERT_IMPL(a_pend_has_out, pend_valid_q, out_valid_q, "pending beat without a first beat in flight")
  `PST_ASSERT_IMPL(a_notlast_pend, out_valid_q && !out_last_q, pend_valid_q, "non-final beat with no second beat pending")
  `PST_ASSERT_IMPL(a_no_take_pend, pend_valid_q, !take, "new event taken while a second beat is pending")

endmodule

`default_nettype wire

// ===== rtl/pointer_selection_tracker.sv =====
// Path: an event passes front-end stages 1 and 2, the queue and the command
//   unit's output register; a second beat waits in the pending register.
// Throughput: the front end takes one event per cycle unless stalled; the
//   command unit issues one beat per cycle while the sink is ready.
// Reset: rst_ni low clears the pipeline, queue and beats, puts the cursor at
//   cell 1,1 with no anchor or click, and sets the screen to 80 by 25.
// ----------------------------------------------------------------------------
// pointer_selection_tracker
// Text-console pointer selection tracker: front end, event queue, command unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_selection_tracker #(
  parameter int unsigned COORD_BITS   = pst_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS    = pst_pkg::FRAC_BITS_DEF,
  parameter int unsigned MOVE_DIVISOR = pst_pkg::MOVE_DIVISOR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pst_evt_if.sink     evt_i,
  pst_cmd_if.source   cmd_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pst_pkg::*;

  localparam int unsigned DeltaBits = VALUE_BITS + FRAC_BITS + 1;
  localparam int unsigned EntryBits = 3 + 2 * VALUE_BITS + 2 * DeltaBits;

  logic [COORD_BITS-1:0]        cols_lim;
  logic [COORD_BITS-1:0]        rows_lim;
  logic                         f_valid;
  logic                         f_ready;
  op_e                          f_op;
  logic signed [VALUE_BITS-1:0] f_h;
  logic signed [VALUE_BITS-1:0] f_v;
  logic signed [DeltaBits-1:0]  f_dcol;
  logic signed [DeltaBits-1:0]  f_drow;
  logic [EntryBits-1:0]         push_data;
  logic [EntryBits-1:0]         pop_data;
  logic                         b_valid;
  logic                         b_ready;
  logic [2:0]                   b_op;
  logic signed [VALUE_BITS-1:0] b_h;
  logic signed [VALUE_BITS-1:0] b_v;
  logic signed [DeltaBits-1:0]  b_dcol;
  logic signed [DeltaBits-1:0]  b_drow;

  // configuration registers
  pst_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cols_lim_o (cols_lim),
    .rows_lim_o (rows_lim)
  );

  // event front end
  pst_front #(
    .FRAC_BITS    (FRAC_BITS),
    .MOVE_DIVISOR (MOVE_DIVISOR)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_op_o    (f_op),
    .q_horiz_o (f_h),
    .q_vert_o  (f_v),
    .q_dcol_o  (f_dcol),
    .q_drow_o  (f_drow)
  );

  // queue entry packing
  assign push_data = {f_op, f_h, f_v, f_dcol, f_drow};
  assign {b_op, b_h, b_v, b_dcol, b_drow} = pop_data;

  pst_queue #(
    .WIDTH (EntryBits)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (pop_data)
  );

  // command unit
  pst_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (b_valid),
    .q_ready_o  (b_ready),
    .q_op_i     (b_op),
    .q_horiz_i  (b_h),
    .q_vert_i   (b_v),
    .q_dcol_i   (b_dcol),
    .q_drow_i   (b_drow),
    .cols_lim_i (cols_lim),
    .rows_lim_i (rows_lim),
    .cmd_o      (cmd_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pointer selection tracker. A directed list of
// pointer events, then random gestures (drag, multi-click, right click,
// wheel, noise) under several screen sizes. Every accepted event runs
// through a local predictor. Command beats are compared field by field
// against the predicted queue. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int unsigned COORD_BITS   = COORD_BITS_DEF;
  localparam int unsigned FRAC_BITS    = FRAC_BITS_DEF;
  localparam int unsigned MOVE_DIVISOR = MOVE_DIVISOR_DEF;

  localparam int  EVENTS_PER_PHASE = 130;
  localparam int  SETTLE_CYCLES    = 8;
  localparam longint CYCLE_LIMIT   = 400000;

  localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};
  localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};

  typedef logic [COORD_BITS-1:0] cell_t;

  typedef struct {
    op_e                          op;
    logic signed [VALUE_BITS-1:0] horiz;
    logic signed [VALUE_BITS-1:0] vert;
  } ptr_event_t;

  typedef struct {
    cmd_e              cmd;
    cell_t             cur_col;
    cell_t             cur_row;
    cell_t             cor_col;
    cell_t             cor_row;
    logic [1:0]        btn;
    logic signed [2:0] scroll;
    logic              last;
  } cmd_beat_t;

  // one directed row; the final beat is spelled out where typed is set
  typedef struct {
    op_e               op;
    int                horiz;
    int                vert;
    bit                typed;
    cmd_e              cmd;
    int                cur_col;
    int                cur_row;
    int                cor_col;
    int                cor_row;
    logic [1:0]        btn;
    logic signed [2:0] scroll;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    '{OP_SET,      -32768, -32768, 1, CMD_DRAW,       1,  1,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_SET,       32767,  32767, 1, CMD_DRAW,      80, 25,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_MOVE,      32767,  32767, 1, CMD_DRAW,      80, 25,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_MOVE,     -32768, -32768, 1, CMD_DRAW,       1,  1,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_MOVE,         19,    -19, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_WHEEL,     12345,      0, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_WHEEL,        -1,      1, 1, CMD_SCROLL,     1,  1,  0, 0, BTN_NONE,  SCROLL_UP},
    '{OP_WHEEL,     32767, -32768, 1, CMD_SCROLL,     1,  1,  0, 0, BTN_NONE,  SCROLL_DOWN},
    '{OP_MPRESS,       -1,     -1, 1, CMD_PASTE,      1,  1,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_RPRESS,        0,      0, 1, CMD_REPORT,     1,  1,  0, 0, BTN_RIGHT, SCROLL_NONE},
    '{OP_RRELEASE,      0,      0, 1, CMD_REPORT,     1,  1,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_SET,           9,      4, 1, CMD_DRAW,      10,  5,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 1, CMD_SEL_REGION, 10, 5, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_MOVE,        100,     40, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_LRELEASE,      0,      0, 1, CMD_REPORT,    15,  7,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_SET,           9,      4, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 1, CMD_SEL_WORDS, 10,  5, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 1, CMD_SEL_LINES, 10,  5, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 1, CMD_SEL_REGION, 10, 5, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_MOVE,         20,    -20, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE},
    '{OP_SET,           0,      0, 1, CMD_SEL_REGION, 1,  1, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_RPRESS,        0,      0, 1, CMD_SEL_REGION, 1,  1, 10, 5, BTN_NONE,  SCROLL_NONE},
    '{OP_LPRESS,        0,      0, 1, CMD_SEL_REGION, 1,  1,  1, 1, BTN_NONE,  SCROLL_NONE},
    '{OP_LRELEASE,      0,      0, 0, CMD_DRAW,       0,  0,  0, 0, BTN_NONE,  SCROLL_NONE}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pst_evt_if evt_bus ();
  pst_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();

  pointer_selection_tracker #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .MOVE_DIVISOR(MOVE_DIVISOR)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_bus),
    .cmd_o  (cmd_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Tracker state mirror, starts at reset values
  longint     pos_col_q   = longint'(1) << FRAC_BITS;
  longint     pos_row_q   = longint'(1) << FRAC_BITS;
  cell_t      anchor_col  = '0;
  cell_t      anchor_row  = '0;
  bit         anchor_set  = 1'b0;
  cell_t      click_col   = '0;
  cell_t      click_row   = '0;
  bit         click_set   = 1'b0;
  logic [1:0] sel_gran    = GRAN_REGION;
  logic [1:0] held_btn    = BTN_NONE;
  cell_t      screen_cols = cell_t'(COLS_RESET);
  cell_t      screen_rows = cell_t'(ROWS_RESET);

  cmd_beat_t  cmd_due_q[$];
  int         err_count  = 0;
  int         events_fed = 0;
  longint     cycle_count = 0;
  bit         src_burst  = 1'b0;
  bit         snk_burst  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Clamp a Q12.8 position to 1.0 .. limit, a zero limit counting as 1
  function automatic longint clamp_pos(longint p, cell_t limit);
    longint unit_q;
    longint top_q;
    unit_q = longint'(1) << FRAC_BITS;
    top_q  = ((limit == '0) ? longint'(1) : longint'(limit)) * unit_q;
    if (p < unit_q) return unit_q;
    if (p > top_q) return top_q;
    return p;
  endfunction

  function automatic cell_t pos_to_cell(longint p);
    return cell_t'(p >> FRAC_BITS);
  endfunction

  function automatic cmd_e select_cmd(logic [1:0] g);
    case (g)
      GRAN_WORDS: return CMD_SEL_WORDS;
      GRAN_LINES: return CMD_SEL_LINES;
      default:    return CMD_SEL_REGION;
    endcase
  endfunction

  function automatic void push_beat(cmd_e c, cell_t kc, cell_t kr, logic [1:0] b,
                                    logic signed [2:0] s);
    cmd_beat_t bt;
    bt.cmd     = c;
    bt.cur_col = pos_to_cell(pos_col_q);
    bt.cur_row = pos_to_cell(pos_row_q);
    bt.cor_col = kc;
    bt.cor_row = kr;
    bt.btn     = b;
    bt.scroll  = s;
    bt.last    = 1'b0;
    cmd_due_q.push_back(bt);
  endfunction

  // Work out the command beats of one event and update the mirror
  function automatic void predict_commands(ptr_event_t e);
    int     depth0;
    longint unit_q;
    longint dh;
    longint dv;
    cell_t  cc;
    cell_t  cr;
    depth0 = cmd_due_q.size();
    unit_q = longint'(1) << FRAC_BITS;
    dh     = longint'(e.horiz);
    dv     = longint'(e.vert);
    case (e.op)
      OP_SET: begin
        pos_col_q = clamp_pos((dh + 1) * unit_q, screen_cols);
        pos_row_q = clamp_pos((dv + 1) * unit_q, screen_rows);
        // with an anchor set, set selects by region
        if (anchor_set) push_beat(CMD_SEL_REGION, anchor_col, anchor_row, BTN_NONE, SCROLL_NONE);
        else push_beat(CMD_DRAW, '0, '0, BTN_NONE, SCROLL_NONE);
      end
      OP_MOVE: begin
        // signed division truncates toward zero
        pos_col_q = clamp_pos(pos_col_q + (dh * unit_q) / longint'(MOVE_DIVISOR),
                              screen_cols);
        pos_row_q = clamp_pos(pos_row_q + (dv * unit_q) / longint'(MOVE_DIVISOR),
                              screen_rows);
        if (anchor_set) begin
          push_beat(select_cmd(sel_gran), anchor_col, anchor_row, BTN_NONE, SCROLL_NONE);
        end else begin
          push_beat(CMD_DRAW, '0, '0, BTN_NONE, SCROLL_NONE);
        end
      end
      OP_LPRESS: begin
        held_btn = BTN_LEFT;
        push_beat(CMD_REPORT, '0, '0, held_btn, SCROLL_NONE);
        cc = pos_to_cell(pos_col_q);
        cr = pos_to_cell(pos_row_q);
        // repeated click on the same cell cycles region, words, lines
        if (click_set && click_col == cc && click_row == cr) begin
          sel_gran = (sel_gran == GRAN_LINES) ? GRAN_REGION : sel_gran + 2'd1;
        end else begin
          sel_gran = GRAN_REGION;
        end
        push_beat(select_cmd(sel_gran), cc, cr, BTN_NONE, SCROLL_NONE);
        anchor_col = cc;
        anchor_row = cr;
        click_col  = cc;
        click_row  = cr;
        anchor_set = 1'b1;
        click_set  = 1'b1;
      end
      OP_LRELEASE: begin
        held_btn = BTN_NONE;
        push_beat(CMD_REPORT, '0, '0, held_btn, SCROLL_NONE);
        anchor_set = 1'b0;
      end
      OP_MPRESS: push_beat(CMD_PASTE, '0, '0, BTN_NONE, SCROLL_NONE);
      OP_RPRESS: begin
        held_btn = BTN_RIGHT;
        push_beat(CMD_REPORT, '0, '0, held_btn, SCROLL_NONE);
        if (click_set) push_beat(CMD_SEL_REGION, click_col, click_row, BTN_NONE, SCROLL_NONE);
      end
      OP_RRELEASE: begin
        held_btn = BTN_NONE;
        push_beat(CMD_REPORT, '0, '0, held_btn, SCROLL_NONE);
      end
      OP_WHEEL: begin
        // zero wheel amount yields nothing
        if (e.vert != 0) begin
          push_beat(CMD_SCROLL, '0, '0, BTN_NONE, (e.vert > 0) ? SCROLL_UP : SCROLL_DOWN);
        end
      end
    endcase
    if (cmd_due_q.size() > depth0) cmd_due_q[cmd_due_q.size()-1].last = 1'b1;
  endfunction

  // Per-beat wait, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic void field_ok(string name, logic signed [31:0] want,
                                   logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_beat();
    cmd_beat_t want;
    if (cmd_due_q.size() == 0) begin
      $error("command beat with none pending: command %0d", cmd_bus.command);
      err_count++;
      return;
    end
    want = cmd_due_q.pop_front();
    field_ok("command",       want.cmd,     cmd_bus.command);
    field_ok("cursor_col",    want.cur_col, cmd_bus.cursor_col);
    field_ok("cursor_row",    want.cur_row, cmd_bus.cursor_row);
    field_ok("corner_col",    want.cor_col, cmd_bus.corner_col);
    field_ok("corner_row",    want.cor_row, cmd_bus.corner_row);
    field_ok("button_state",  want.btn,     cmd_bus.button_state);
    field_ok("scroll_amount", want.scroll,  cmd_bus.scroll_amount);
    field_ok("last",          want.last,    cmd_bus.last);
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535));
  endfunction

  // Mostly on or just past the screen, now and then any 16-bit value
  function automatic int rand_coord(cell_t limit);
    if ($urandom_range(0, 9) == 0) return rand16();
    return int'($urandom_range(0, (limit == '0) ? 1 : int'(limit)));
  endfunction

  function automatic int rand_delta();
    if ($urandom_range(0, 7) == 0) return rand16();
    return int'($urandom_range(0, 60)) - 30;
  endfunction

  // Send one event beat and predict its commands at the accepting edge
  task automatic feed(input op_e op, input int h, input int v);
    ptr_event_t e;
    int         gap;
    e.op    = op;
    e.horiz = h[VALUE_BITS-1:0];
    e.vert  = v[VALUE_BITS-1:0];
    gap = draw_gap(src_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    evt_bus.valid       <= 1'b1;
    evt_bus.op          <= e.op;
    evt_bus.horiz_value <= e.horiz;
    evt_bus.vert_value  <= e.vert;
    do @(posedge clk_i); while (!evt_bus.ready);
    predict_commands(e);
    if (!(op == OP_WHEEL && e.vert == 0)) events_fed++;
  endtask

  // One random gesture; most are well-formed, the rest noise
  task automatic run_gesture();
    int kind;
    int reps;
    kind = $urandom_range(0, 99);
    reps = $urandom_range(1, 4);
    if (kind < 30) begin
      // click and drag
      feed(OP_SET, rand_coord(screen_cols), rand_coord(screen_rows));
      feed(OP_LPRESS, rand16(), rand16());
      repeat (reps) feed(OP_MOVE, rand_delta(), rand_delta());
      feed(OP_LRELEASE, rand16(), rand16());
    end else if (kind < 50) begin
      // multi-click, sometimes nudged between clicks
      feed(OP_SET, rand_coord(screen_cols), rand_coord(screen_rows));
      repeat (reps) begin
        feed(OP_LPRESS, rand16(), rand16());
        if ($urandom_range(0, 3) == 0) begin
          feed(OP_MOVE, int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
        end
        feed(OP_LRELEASE, rand16(), rand16());
      end
    end else if (kind < 65) begin
      // right click extends from the last left click
      feed(OP_SET, rand_coord(screen_cols), rand_coord(screen_rows));
      feed(OP_RPRESS, rand16(), rand16());
      if ($urandom_range(0, 1) == 0) feed(OP_MOVE, rand_delta(), rand_delta());
      feed(OP_RRELEASE, rand16(), rand16());
    end else if (kind < 75) begin
      feed(OP_WHEEL, rand16(), ($urandom_range(0, 3) == 0) ? 0 : rand16());
    end else begin
      feed(op_e'(3'($urandom_range(0, 7))), rand16(), rand16());
    end
  endtask

  task automatic run_phase();
    int base;
    base = events_fed;
    while (events_fed - base < EVENTS_PER_PHASE) run_gesture();
  endtask

  // Drop valid, wait out every pending beat and the pipeline tail
  task automatic drain();
    @(negedge clk_i);
    evt_bus.valid <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_COLS) screen_cols = data[COORD_BITS-1:0];
    else screen_rows = data[COORD_BITS-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Command sink with random stalls
  initial begin
    int gap;
    cmd_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(snk_burst);
      @(negedge clk_i);
      if (gap > 0) begin
        cmd_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      cmd_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!cmd_bus.valid);
      check_beat();
    end
  end

  // Main sequence
  initial begin
    dir_row_t    row;
    cmd_beat_t   typed_beat;
    logic [31:0] col_set [5];
    logic [31:0] row_set [5];
    evt_bus.valid       = 1'b0;
    evt_bus.op          = OP_SET;
    evt_bus.horiz_value = '0;
    evt_bus.vert_value  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed list at reset screen size
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      feed(row.op, row.horiz, row.vert);
      if (row.typed) begin
        typed_beat.cmd     = row.cmd;
        typed_beat.cur_col = cell_t'(row.cur_col);
        typed_beat.cur_row = cell_t'(row.cur_row);
        typed_beat.cor_col = cell_t'(row.cor_col);
        typed_beat.cor_row = cell_t'(row.cor_row);
        typed_beat.btn     = row.btn;
        typed_beat.scroll  = row.scroll;
        typed_beat.last    = 1'b1;
        cmd_due_q[cmd_due_q.size()-1] = typed_beat;
      end
    end
    run_phase();

    // zero limits, full range, masked upper bits, random, back to reset size
    col_set = '{32'd0, 32'd4095, 32'hFFFF_F001, 32'($urandom_range(2, 200)), COLS_RESET};
    row_set = '{32'd0, 32'd4095, 32'hFFFF_F0FF, 32'($urandom_range(2, 60)), ROWS_RESET};
    foreach (col_set[p]) begin
      drain();
      write_reg(ADDR_COLS, col_set[p]);
      write_reg(ADDR_ROWS, row_set[p]);
      run_phase();
    end
    drain();

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
